/* sv/mtx_pkg.sv */
// Shared types, constants and word functions for the MT19937 keystream XOR block.
// No dependencies.
`default_nettype none

package mtx_pkg;

	localparam int unsigned TW_N = 624;
	localparam int unsigned TW_M = 397;
	localparam int unsigned AW   = 10;
	localparam int unsigned WW   = 32;

	typedef logic [WW-1:0] word_t;
	typedef logic [AW-1:0] addr_t;

	localparam word_t TW_MATRIX_A  = 32'h9908_b0df;
	localparam word_t TW_UPPER     = 32'h8000_0000;
	localparam word_t TW_LOWER     = 32'h7fff_ffff;
	localparam word_t TW_INIT_MULT = 32'd1812433253;
	localparam word_t KEY_MIX      = 32'ha9c3_6de1;
	localparam int unsigned KEY_SHIFT = 7;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_TW_RD0,
		ST_TW_RD1,
		ST_TWIST
	} state_t;

	function automatic word_t temper(input word_t w);
		word_t y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & 32'h9d2c_5680);
		y = y ^ ((y << 15) & 32'hefc6_0000);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
		word_t y;
		word_t v;
		y = (cur & TW_UPPER) | (nxt & TW_LOWER);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TW_MATRIX_A;
		end
		return v;
	endfunction

	function automatic word_t seed_of(input word_t key);
		return (key << KEY_SHIFT) ^ KEY_MIX;
	endfunction

endpackage

`default_nettype wire

/* sv/mt19937_keystream_xor.sv */
// MT19937 keystream XOR, top level: sequencer, seeding and twist datapath, output register.
// Depends on mtx_pkg and mtx_ram.
`default_nettype none

// Scrambles or descrambles a byte stream: each byte is XORed with the low byte of the next
// tempered MT19937 word. A byte flagged start_of_file (or the first byte after reset)
// re-seeds the generator from ((file_key << 7) ^ 0xa9c36de1). The 624-word state sits in
// one two-read-port RAM. Steady bytes are taken back to back unless out_stall holds the
// output; each passes the stage-1 and output registers. Every 624th byte the state is
// twisted first, one word per cycle through the RAM. A re-seed writes the 624 words (one
// multiply and one add per word after the first), then twists; input stalls in both passes.
// file_key may be written only while no byte is in flight; it applies at the next start.

module mt19937_keystream_xor
	import mtx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        file_key_valid,
	output logic             file_key_ready,
	input  wire logic [31:0] file_key,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_of_file,
	input  wire logic        end_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  out_byte,
	output logic             last_byte
);

	state_t state_q, state_d;

	word_t  file_key_q;
	addr_t  pos_q;
	logic   seeded_q;
	addr_t  idx_q;
	word_t  p_q;
	word_t  prod_q;
	word_t  cur_q;

	logic       s1_valid_q;
	logic [7:0] s1_byte_s1;
	logic       s1_last_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_byte_q;

	logic  we, re_a, re_b;
	addr_t waddr, raddr_a, raddr_b;
	word_t wdata, rdata_a, rdata_b;

	logic  in_take, s1_go, need_seed, need_twist, idx_last;
	logic [AW:0] nxt_sum, far_sum;
	addr_t nxt_addr, far_addr;
	word_t mix;
	word_t ks;

	mtx_ram #(
		.WIDTH(WW),
		.DEPTH(TW_N),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re_a(re_a),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.re_b(re_b),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	assign file_key_ready = 1'b1;

	assign s1_go = s1_valid_q && (state_q == ST_RUN) && (!out_valid_q || !out_stall);
	assign in_stall = !((state_q == ST_RUN) && (!s1_valid_q || s1_go));
	assign in_take = in_valid && !in_stall;
	assign need_seed = start_of_file || !seeded_q;
	assign need_twist = pos_q >= AW'(TW_N);
	assign idx_last = idx_q == AW'(TW_N - 1);

	// addresses for word k+1 of the stream: next is k+2, far is k+1+M, both modulo N
	assign nxt_sum = {1'b0, idx_q} + (AW + 1)'(2);
	assign far_sum = {1'b0, idx_q} + (AW + 1)'(TW_M + 1);
	assign nxt_addr = (nxt_sum >= (AW + 1)'(TW_N)) ? AW'(nxt_sum - (AW + 1)'(TW_N)) : nxt_sum[AW-1:0];
	assign far_addr = (far_sum >= (AW + 1)'(TW_N)) ? AW'(far_sum - (AW + 1)'(TW_N)) : far_sum[AW-1:0];

	assign mix = p_q ^ (p_q >> 30);
	assign ks = temper(rdata_a);

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = p_q;
		re_a    = 1'b0;
		raddr_a = pos_q;
		re_b    = 1'b0;
		raddr_b = far_addr;
		unique case (state_q)
			ST_RUN: begin
				if (in_take) begin
					if (need_seed) begin
						state_d = ST_SEED_MUL;
					end else if (need_twist) begin
						state_d = ST_TW_RD0;
					end else begin
						re_a = 1'b1;
					end
				end
			end
			ST_SEED_MUL: begin
				we = 1'b1;
				state_d = idx_last ? ST_TW_RD0 : ST_SEED_ADD;
			end
			ST_SEED_ADD: begin
				state_d = ST_SEED_MUL;
			end
			ST_TW_RD0: begin
				re_a    = 1'b1;
				raddr_a = '0;
				state_d = ST_TW_RD1;
			end
			ST_TW_RD1: begin
				re_a    = 1'b1;
				raddr_a = AW'(1);
				re_b    = 1'b1;
				raddr_b = AW'(TW_M);
				state_d = ST_TWIST;
			end
			ST_TWIST: begin
				we    = 1'b1;
				wdata = twist_word(cur_q, rdata_a, rdata_b);
				re_a  = 1'b1;
				if (idx_last) begin
					raddr_a = '0;
					state_d = ST_RUN;
				end else begin
					raddr_a = nxt_addr;
					re_b    = 1'b1;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_key_q  <= '0;
			pos_q       <= '0;
			seeded_q    <= 1'b0;
			idx_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (file_key_valid && file_key_ready) begin
				file_key_q <= file_key;
			end

			if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (in_take) begin
				s1_valid_q <= 1'b1;
				if (need_seed) begin
					seeded_q <= 1'b1;
					idx_q    <= '0;
				end else if (!need_twist) begin
					pos_q <= pos_q + AW'(1);
				end
			end

			case (state_q)
				ST_SEED_ADD: idx_q <= idx_q + AW'(1);
				ST_TW_RD1:   idx_q <= '0;
				ST_TWIST: begin
					idx_q <= idx_q + AW'(1);
					if (idx_last) begin
						pos_q <= AW'(1);
					end
				end
				default: ;
			endcase

			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			s1_byte_s1 <= data_byte;
			s1_last_s1 <= end_of_file;
			if (need_seed) begin
				p_q <= seed_of(file_key_q);
			end
		end
		case (state_q)
			ST_SEED_MUL: prod_q <= word_t'(mix * TW_INIT_MULT);
			ST_SEED_ADD: p_q <= prod_q + word_t'(idx_q) + word_t'(1);
			ST_TW_RD1:   cur_q <= rdata_a;
			ST_TWIST:    cur_q <= rdata_a;
			default: ;
		endcase
		if (s1_go) begin
			out_byte_q  <= s1_byte_s1 ^ ks[7:0];
			last_byte_q <= s1_last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_byte_q;

endmodule

`default_nettype wire

/* sv/mtx_ram.sv */
// Generic synchronous RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module mtx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re_a,
	input  wire logic [AW-1:0]    raddr_a,
	output logic      [WIDTH-1:0] rdata_a,
	input  wire logic             re_b,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a_q <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

`default_nettype wire
